/* hw/rtl/mlt_pkg.sv */
// Shared types and constants for the MAC learning table.
`default_nettype none

package mlt_pkg;

    localparam int SWITCHES_DEF = 16;
    localparam int ENTRIES_DEF  = 64;

    localparam logic [1:0]  OP_ARRIVE  = 2'd0;
    localparam logic [1:0]  OP_EXPIRE  = 2'd1;
    localparam logic [1:0]  OP_CONNECT = 2'd2;

    localparam logic [47:0] BCAST_MAC  = 48'hFFFF_FFFF_FFFF;
    localparam logic [15:0] PRIO_RESET = 16'd100;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  switch_index;
        logic [15:0] in_port;
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
        logic        table_miss;
    } req_t;

    typedef struct packed {
        logic [15:0] out_port;
        logic        flood;
        logic        learned;
        logic [15:0] flow_priority;
        logic        port_conflict;
        logic        table_full;
        logic        bad_source;
    } rsp_t;

    typedef struct packed {
        logic        valid;
        logic [47:0] mac;
        logic [15:0] port;
    } entry_t;

endpackage

`default_nettype wire

/* hw/rtl/mac_learning_table.sv */
// MAC learning table: per-switch L2 learning bridge lookup and learn engine.
`default_nettype none

// Usage:
//   s_valid/s_ready/s_data carry one event request (packet arrival, flow expiry,
//   switch connect). m_valid/m_ready/m_data carry one forwarding decision for
//   each table-miss packet arrival; other events give no result.
//   All tables share one memory of SWITCHES*ENTRIES words, one read and one
//   write per cycle. A table-miss arrival or an expiry on an active switch
//   walks that switch's ENTRIES slots once, reading one slot per cycle and
//   checking it against the destination and, for an arrival, against the
//   source, then updates the table. The block takes its next request only
//   once it is back in the idle state, so a request is not taken while the
//   last one is still scanning or updating.
//   Connecting a switch that was inactive clears its ENTRIES slots, one per
//   cycle; other connects and ignored events leave the block idle.
//   A table-miss arrival on an inactive switch answers flood without a scan.
//   Reset clears all switch active bits and sets the priority counter to 100;
//   tables are cleared lazily on connect, so no sweep follows reset.
//   A stalled receiver holds the result in the output register; the next
//   request is accepted meanwhile and its result waits until that one leaves.
module mac_learning_table
    import mlt_pkg::*;
#(
    parameter int SWITCHES = SWITCHES_DEF,
    parameter int ENTRIES  = ENTRIES_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire req_t s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output rsp_t      m_data
);

    localparam int DEPTH  = SWITCHES * ENTRIES;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int SW_W   = (SWITCHES > 1) ? $clog2(SWITCHES) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN,
        ST_UPDATE,
        ST_RESP
    } state_t;

    state_t              state_reg;
    req_t                req_reg;
    logic [ADDR_W-1:0]   base_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                rd_valid_reg;
    logic [SWITCHES-1:0] active_reg;
    logic [15:0]         last_prio_reg;
    rsp_t                res_reg;
    logic                m_valid_reg;
    rsp_t                m_data_reg;

    // scan results
    logic                dst_hit_reg;
    logic [IDX_W-1:0]    dst_slot_reg;
    logic [15:0]         dst_port_reg;
    logic                src_hit_reg;
    logic [15:0]         src_port_reg;
    logic                free_hit_reg;
    logic [IDX_W-1:0]    free_slot_reg;

    // table memory
    entry_t              mem [DEPTH];
    entry_t              rdata_reg;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    entry_t              mem_wdata;
    logic [ADDR_W-1:0]   mem_raddr;

    logic [SW_W-1:0]     sw_idx;
    logic                sw_in_range;
    logic                sw_active;
    logic [ADDR_W-1:0]   base_next;
    logic                dst_chk;
    logic                src_chk;
    logic                dst_match;
    logic                src_match;
    rsp_t                res_next;
    rsp_t                flood_rsp;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign sw_idx      = SW_W'(s_data.switch_index);
    assign sw_in_range = 32'(s_data.switch_index) < SWITCHES;
    assign sw_active   = sw_in_range && active_reg[sw_idx];
    assign base_next   = ADDR_W'(sw_idx * ENTRIES);

    // broadcast destination skips the lookup on arrival; expiry always looks up
    assign dst_chk = (req_reg.opcode == OP_EXPIRE) || (req_reg.dst_mac != BCAST_MAC);
    assign src_chk = (req_reg.opcode == OP_ARRIVE) && (req_reg.src_mac != BCAST_MAC);

    assign dst_match = rdata_reg.valid && dst_chk && (rdata_reg.mac == req_reg.dst_mac);
    assign src_match = rdata_reg.valid && src_chk && (rdata_reg.mac == req_reg.src_mac);

    assign mem_raddr = base_reg + ADDR_W'(cnt_reg[IDX_W-1:0]);

    always_comb begin
        flood_rsp       = '0;
        flood_rsp.flood = 1'b1;
    end

    always_comb begin
        res_next               = '0;
        res_next.out_port      = dst_hit_reg ? dst_port_reg : 16'd0;
        res_next.flood         = !dst_hit_reg;
        res_next.bad_source    = !src_chk;
        res_next.learned       = src_chk && !src_hit_reg && free_hit_reg;
        res_next.flow_priority = (src_chk && !src_hit_reg && free_hit_reg) ?
                                 last_prio_reg + 16'd1 : 16'd0;
        res_next.port_conflict = src_chk && src_hit_reg && (src_port_reg != req_reg.in_port);
        res_next.table_full    = src_chk && !src_hit_reg && !free_hit_reg;
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = base_reg;
        mem_wdata = '0;
        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = base_reg + ADDR_W'(cnt_reg[IDX_W-1:0]);
            end
            ST_UPDATE: begin
                if (req_reg.opcode == OP_EXPIRE) begin
                    mem_we    = dst_hit_reg;
                    mem_waddr = base_reg + ADDR_W'(dst_slot_reg);
                end else begin
                    mem_we          = src_chk && !src_hit_reg && free_hit_reg;
                    mem_waddr       = base_reg + ADDR_W'(free_slot_reg);
                    mem_wdata.valid = 1'b1;
                    mem_wdata.mac   = req_reg.src_mac;
                    mem_wdata.port  = req_reg.in_port;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            active_reg    <= '0;
            last_prio_reg <= PRIO_RESET;
            rd_valid_reg  <= 1'b0;
        end else begin
            // the response state reloads the output register itself
            if (m_valid_reg && m_ready && state_reg != ST_RESP) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        req_reg      <= s_data;
                        base_reg     <= base_next;
                        cnt_reg      <= '0;
                        dst_hit_reg  <= 1'b0;
                        src_hit_reg  <= 1'b0;
                        free_hit_reg <= 1'b0;
                        case (s_data.opcode)
                            OP_CONNECT: begin
                                // a fresh table starts empty
                                if (sw_in_range && !active_reg[sw_idx]) begin
                                    active_reg[sw_idx] <= 1'b1;
                                    state_reg          <= ST_CLEAR;
                                end
                            end
                            OP_EXPIRE: begin
                                if (sw_active) begin
                                    state_reg <= ST_SCAN;
                                end
                            end
                            OP_ARRIVE: begin
                                if (s_data.table_miss) begin
                                    if (sw_active) begin
                                        state_reg <= ST_SCAN;
                                    end else begin
                                        res_reg   <= flood_rsp;
                                        state_reg <= ST_RESP;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end

                ST_CLEAR: begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(ENTRIES - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_SCAN: begin
                    rd_valid_reg <= (cnt_reg != CNT_W'(ENTRIES));
                    if (cnt_reg != CNT_W'(ENTRIES)) begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                    if (rd_valid_reg) begin
                        // lowest matching or free slot wins
                        if (dst_match && !dst_hit_reg) begin
                            dst_hit_reg  <= 1'b1;
                            dst_slot_reg <= IDX_W'(cnt_reg - CNT_W'(1));
                            dst_port_reg <= rdata_reg.port;
                        end
                        if (src_match && !src_hit_reg) begin
                            src_hit_reg  <= 1'b1;
                            src_port_reg <= rdata_reg.port;
                        end
                        if (!rdata_reg.valid && !free_hit_reg) begin
                            free_hit_reg  <= 1'b1;
                            free_slot_reg <= IDX_W'(cnt_reg - CNT_W'(1));
                        end
                    end
                    if (cnt_reg == CNT_W'(ENTRIES) && !rd_valid_reg) begin
                        state_reg <= ST_UPDATE;
                    end
                end

                ST_UPDATE: begin
                    if (req_reg.opcode == OP_EXPIRE) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        res_reg <= res_next;
                        if (res_next.learned) begin
                            last_prio_reg <= res_next.flow_priority;
                        end
                        state_reg <= ST_RESP;
                    end
                end

                ST_RESP: begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg  <= res_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // a learned result carries no error flag
    a_learn_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.learned |->
            !m_data_reg.table_full && !m_data_reg.bad_source && !m_data_reg.port_conflict)
        else $error("learned result with error flag");

    // flooding never reports a port
    a_flood_port: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.flood |-> m_data_reg.out_port == 16'd0)
        else $error("flood result with nonzero port");

    // writes stay inside the current switch's table
    a_write_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (mem_waddr >= base_reg) &&
            ({1'b0, mem_waddr} < ({1'b0, base_reg} + (ADDR_W + 1)'(ENTRIES))))
        else $error("table write outside switch region");

    // an accepted connect to a new switch starts a clear pass
    a_connect_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.opcode == OP_CONNECT && sw_in_range &&
            !active_reg[sw_idx] |=> state_reg == ST_CLEAR && cnt_reg == '0)
        else $error("connect did not start clear pass");

endmodule

`default_nettype wire

/* tb/mac_decision_checker.sv */
// Scoreboard for the MAC learning table: tracks switch tables, predicts and checks decisions.
`timescale 1ns / 1ps

module mac_decision_checker
    import mlt_pkg::*;
#(
    parameter int SW_N  = SWITCHES_DEF,
    parameter int ENT_N = ENTRIES_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    input  wire logic s_ready,
    input  wire req_t s_data,
    input  wire logic m_valid,
    input  wire logic m_ready,
    input  wire rsp_t m_data,
    output int        fail_count,
    output int        pending
);

    // shadow copy of the per-switch tables
    logic        sw_on     [SW_N];
    logic        slot_used [SW_N][ENT_N];
    logic [47:0] slot_mac  [SW_N][ENT_N];
    logic [15:0] slot_port [SW_N][ENT_N];
    logic [15:0] prio_ctr;

    rsp_t decisions_due[$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic clear_tables();
        for (int s = 0; s < SW_N; s++) begin
            sw_on[s] = 1'b0;
            for (int k = 0; k < ENT_N; k++) begin
                slot_used[s][k] = 1'b0;
            end
        end
        prio_ctr = PRIO_RESET;
        decisions_due.delete();
    endtask

    function automatic int find_slot(input int sw, input logic [47:0] mac);
        for (int k = 0; k < ENT_N; k++) begin
            if (slot_used[sw][k] && slot_mac[sw][k] == mac) return k;
        end
        return -1;
    endfunction

    // updates the shadow tables; returns 1 when the request yields a decision
    function automatic bit predict_decision(input req_t rq, output rsp_t d);
        int sw;
        int hit;
        int free_slot;
        bit on;
        sw = rq.switch_index;
        on = (sw < SW_N) && sw_on[sw];
        d = '0;
        d.flood = 1'b1;
        case (rq.opcode)
            OP_CONNECT: begin
                if (sw < SW_N) sw_on[sw] = 1'b1;
                return 1'b0;
            end
            OP_EXPIRE: begin
                if (on) begin
                    hit = find_slot(sw, rq.dst_mac);
                    if (hit >= 0) slot_used[sw][hit] = 1'b0;
                end
                return 1'b0;
            end
            OP_ARRIVE: begin
                if (!rq.table_miss) return 1'b0;
                if (on) begin
                    // destination lookup sees the table before this source is learned
                    if (rq.dst_mac != BCAST_MAC) begin
                        hit = find_slot(sw, rq.dst_mac);
                        if (hit >= 0) begin
                            d.out_port = slot_port[sw][hit];
                            d.flood    = 1'b0;
                        end
                    end
                    if (rq.src_mac == BCAST_MAC) begin
                        d.bad_source = 1'b1;
                    end else begin
                        hit = find_slot(sw, rq.src_mac);
                        if (hit >= 0) begin
                            d.port_conflict = (slot_port[sw][hit] != rq.in_port);
                        end else begin
                            free_slot = -1;
                            for (int k = ENT_N - 1; k >= 0; k--) begin
                                if (!slot_used[sw][k]) free_slot = k;
                            end
                            if (free_slot < 0) begin
                                d.table_full = 1'b1;
                            end else begin
                                slot_used[sw][free_slot] = 1'b1;
                                slot_mac[sw][free_slot]  = rq.src_mac;
                                slot_port[sw][free_slot] = rq.in_port;
                                prio_ctr        = prio_ctr + 16'd1;
                                d.learned       = 1'b1;
                                d.flow_priority = prio_ctr;
                            end
                        end
                    end
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic string fmt_decision(input rsp_t d);
        return $sformatf("port=%h flood=%b learned=%b prio=%0d conflict=%b full=%b bad_src=%b",
                         d.out_port, d.flood, d.learned, d.flow_priority,
                         d.port_conflict, d.table_full, d.bad_source);
    endfunction

    task automatic check_decision(input rsp_t got);
        rsp_t  want;
        string bad;
        if (decisions_due.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) $display("chk: unexpected decision: %s", fmt_decision(got));
            return;
        end
        want = decisions_due.pop_front();
        bad  = "";
        if (got.out_port      !== want.out_port)      bad = {bad, " out_port"};
        if (got.flood         !== want.flood)         bad = {bad, " flood"};
        if (got.learned       !== want.learned)       bad = {bad, " learned"};
        if (got.flow_priority !== want.flow_priority) bad = {bad, " flow_priority"};
        if (got.port_conflict !== want.port_conflict) bad = {bad, " port_conflict"};
        if (got.table_full    !== want.table_full)    bad = {bad, " table_full"};
        if (got.bad_source    !== want.bad_source)    bad = {bad, " bad_source"};
        if (bad != "") begin
            fail_count++;
            if (fail_count <= 10) begin
                $display("chk: mismatch in%s", bad);
                $display("chk:   expected %s", fmt_decision(want));
                $display("chk:   actual   %s", fmt_decision(got));
            end
        end
    endtask

    always @(posedge aclk) begin : watch
        rsp_t due;
        bit   has;
        if (!aresetn) begin
            clear_tables();
        end else begin
            if (s_valid && s_ready) begin
                has = predict_decision(s_data, due);
                if (has) decisions_due.push_back(due);
            end
            if (m_valid && m_ready) check_decision(m_data);
        end
        pending = decisions_due.size();
    end

endmodule

/* tb/tb_top.sv */
// Top-level testbench for mac_learning_table: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_top
    import mlt_pkg::*;
();

    // opcode the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int POOL_N      = 24;     // shared MAC pool, small so lookups hit
    localparam int FILL_LEN    = ENTRIES_DEF + 6;
    localparam int PHASE_ITEMS = 300;
    localparam int HOLD_CYCLES = 600;    // long receiver hold-off
    localparam int QUIET_LIMIT = 3000;   // cycles with no handshake before giving up

    localparam logic [47:0] MAC_ZERO = 48'h0000_0000_0000;
    localparam logic [47:0] MAC_HIGH = 48'hFFFF_FFFF_FFFE;
    localparam logic [47:0] MAC_MID  = 48'hA5A5_5A5A_0F0F;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    req_t s_data;
    logic m_valid;
    logic m_ready;
    rsp_t m_data;

    int fail_count;
    int pending;

    // flow-control knobs, percent per cycle
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    bit          hold_req      = 1'b0;

    logic [47:0] mac_pool  [POOL_N];
    logic [15:0] port_pool [4];

    mac_learning_table uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    mac_decision_checker #(
        .SW_N  (SWITCHES_DEF),
        .ENT_N (ENTRIES_DEF)
    ) decision_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // --------------------------------------------------------------------
    // Request helpers
    // --------------------------------------------------------------------
    function automatic req_t mk(input logic [1:0] op, input logic [3:0] sw,
                                input logic [15:0] port, input logic [47:0] src,
                                input logic [47:0] dst, input logic miss);
        req_t r;
        r.opcode       = op;
        r.switch_index = sw;
        r.in_port      = port;
        r.src_mac      = src;
        r.dst_mac      = dst;
        r.table_miss   = miss;
        return r;
    endfunction

    function automatic logic [47:0] fresh_mac();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // mostly pool addresses so sources get relearned and destinations hit;
    // some broadcast, some never seen before
    function automatic logic [47:0] pick_mac(input int unsigned bcast_pct);
        int unsigned p;
        p = $urandom_range(99);
        if (p < bcast_pct) return BCAST_MAC;
        if (p < bcast_pct + 10) return fresh_mac();
        return mac_pool[$urandom_range(POOL_N - 1)];
    endfunction

    function automatic req_t random_event();
        req_t        r;
        int unsigned pick;
        pick = $urandom_range(99);
        // switches 0..7 carry most traffic; the rest show up now and then
        r.switch_index = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(7));
        r.in_port      = ($urandom_range(3) == 0) ? 16'($urandom)
                                                  : port_pool[$urandom_range(3)];
        r.src_mac      = pick_mac(5);
        r.dst_mac      = pick_mac(8);
        r.table_miss   = 1'b1;
        if (pick < 3) begin
            r.opcode = OP_UNUSED;
        end else if (pick < 6) begin
            r.opcode     = OP_ARRIVE;
            r.table_miss = 1'b0;
        end else if (pick < 13) begin
            r.opcode = OP_CONNECT;
        end else if (pick < 26) begin
            r.opcode = OP_EXPIRE;
        end else begin
            r.opcode = OP_ARRIVE;
        end
        return r;
    endfunction

    // Drive one request at the falling edge, hold it until the rising edge
    // that accepts it. Valid stays high into the next call when no gap is
    // taken, so back-to-back requests need no extra cycle.
    task automatic send_req(input req_t r);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Connect a switch and push more fresh sources than it has slots, so the
    // tail of the burst reports a full table; then expire a spread of them
    // so later learns reuse the freed slots.
    task automatic fill_table(input logic [3:0] sw);
        logic [47:0] fill_src [FILL_LEN];
        int          i;
        send_req(mk(OP_CONNECT, sw, '0, '0, '0, 1'b0));
        for (i = 0; i < FILL_LEN; i++) begin
            fill_src[i] = fresh_mac();
            send_req(mk(OP_ARRIVE, sw, 16'($urandom), fill_src[i], pick_mac(5), 1'b1));
        end
        for (i = 0; i < FILL_LEN; i += 6) begin
            send_req(mk(OP_EXPIRE, sw, '0, '0, fill_src[i], 1'b0));
        end
    endtask

    // --------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request so the
    // output register and the input side both back up.
    // --------------------------------------------------------------------
    initial begin : rx_side
        int unsigned held;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++) @(negedge aclk);
                hold_req = 1'b0;
            end
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // --------------------------------------------------------------------
    // Watchdog: too long without any handshake means the block is stuck
    // or a decision never came out.
    // --------------------------------------------------------------------
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    // --------------------------------------------------------------------
    // Stimulus
    // --------------------------------------------------------------------
    initial begin : stim
        req_t        ev;
        int          phase;
        int          counted;
        int          i;
        s_valid = 1'b0;
        s_data  = '0;
        aresetn = 1'b0;

        mac_pool[0] = MAC_ZERO;
        mac_pool[1] = MAC_HIGH;
        for (i = 2; i < POOL_N; i++) mac_pool[i] = fresh_mac();
        port_pool[0] = 16'h0000;
        port_pool[1] = 16'h0001;
        port_pool[2] = 16'h0002;
        port_pool[3] = 16'hFFFF;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // ---- directed part, no idling ----
        // switch 0 still inactive: flood with all flags clear, expiry ignored
        send_req(mk(OP_ARRIVE,  4'd0,  16'h1234, MAC_MID,   MAC_ZERO,  1'b1));
        send_req(mk(OP_EXPIRE,  4'd0,  16'h0000, MAC_ZERO,  MAC_MID,   1'b1));
        send_req(mk(OP_UNUSED,  4'd0,  16'hFFFF, MAC_HIGH,  MAC_HIGH,  1'b1));
        send_req(mk(OP_CONNECT, 4'd0,  16'h0000, MAC_ZERO,  MAC_ZERO,  1'b0));
        // not a table miss on an active switch: no decision, nothing learned
        send_req(mk(OP_ARRIVE,  4'd0,  16'h0000, MAC_ZERO,  BCAST_MAC, 1'b0));
        // first learn takes priority 101; broadcast destination floods
        send_req(mk(OP_ARRIVE,  4'd0,  16'h0000, MAC_ZERO,  BCAST_MAC, 1'b1));
        send_req(mk(OP_ARRIVE,  4'd0,  16'hFFFF, MAC_HIGH,  MAC_ZERO,  1'b1));
        // known source on another port: conflict, old entry kept
        send_req(mk(OP_ARRIVE,  4'd0,  16'h0005, MAC_ZERO,  MAC_HIGH,  1'b1));
        // broadcast source is never learned
        send_req(mk(OP_ARRIVE,  4'd0,  16'h0007, BCAST_MAC, MAC_MID,   1'b1));
        send_req(mk(OP_ARRIVE,  4'd0,  16'h0000, MAC_ZERO,  MAC_ZERO,  1'b1));
        // reconnect keeps the table
        send_req(mk(OP_CONNECT, 4'd0,  16'h0000, MAC_ZERO,  MAC_ZERO,  1'b0));
        send_req(mk(OP_ARRIVE,  4'd0,  16'h0003, MAC_MID,   MAC_HIGH,  1'b1));
        // expire a known MAC, then one that is no longer there
        send_req(mk(OP_EXPIRE,  4'd0,  16'h0000, MAC_ZERO,  MAC_ZERO,  1'b0));
        send_req(mk(OP_EXPIRE,  4'd0,  16'h0000, MAC_ZERO,  MAC_ZERO,  1'b1));
        send_req(mk(OP_ARRIVE,  4'd0,  16'h0009, MAC_HIGH,  MAC_ZERO,  1'b1));
        // relearn into the freed slot; destination lookup precedes learning
        send_req(mk(OP_ARRIVE,  4'd0,  16'h0001, MAC_ZERO,  MAC_MID,   1'b1));
        // highest switch index, tables are per switch
        send_req(mk(OP_CONNECT, 4'd15, 16'h0000, MAC_ZERO,  MAC_ZERO,  1'b0));
        send_req(mk(OP_ARRIVE,  4'd15, 16'hFFFF, MAC_HIGH,  BCAST_MAC, 1'b1));
        send_req(mk(OP_ARRIVE,  4'd15, 16'h8000, BCAST_MAC, BCAST_MAC, 1'b1));
        send_req(mk(OP_EXPIRE,  4'd15, 16'h0000, MAC_ZERO,  MAC_HIGH,  1'b1));
        send_req(mk(OP_ARRIVE,  4'd0,  16'h0001, MAC_MID,   MAC_HIGH,  1'b1));
        send_req(mk(OP_ARRIVE,  4'd15, 16'h0001, MAC_MID,   MAC_ZERO,  1'b1));

        // ---- random part, one idling pattern per phase ----
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    hold_req      = 1'b1;   // back up the block during the fill
                end
                1: begin
                    send_idle_pct = 69;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 69;
                end
                default: begin
                    send_idle_pct = 31;
                    stall_pct     = 31;
                end
            endcase
            if (phase == 0 || phase == 2) fill_table(4'($urandom));
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                ev = random_event();
                send_req(ev);
                // unused opcodes and arrivals that are no table miss do not count toward the phase
                if (ev.opcode != OP_UNUSED && (ev.opcode != OP_ARRIVE || ev.table_miss))
                    counted++;
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        // let any stray decision surface before the verdict
        repeat (ENTRIES_DEF + 16) @(negedge aclk);

        if (fail_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

/* mac_learning_table.f */
hw/rtl/mlt_pkg.sv
hw/rtl/mac_learning_table.sv
tb/mac_decision_checker.sv
tb/tb_top.sv
